// ===== hdl/fit_policy_block_allocator_assert.svh =====
`ifndef FIT_POLICY_BLOCK_ALLOCATOR_ASSERT_SVH
`define FIT_POLICY_BLOCK_ALLOCATOR_ASSERT_SVH

// Condition and consequence checked at the same edge.
`define FPBA_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequence checked at the next edge after the condition.
`define FPBA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/fpba_pkg.sv =====
package fpba_pkg;

   localparam int BLOCK_W     = 4;
   localparam int AMOUNT_W    = 16;
   localparam int BIU_W       = 5;
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 8;

   localparam logic [BIU_W-1:0] BIU_RESET = 5'd16;

   localparam logic [CSR_INDEX_W-1:0] CSR_FIT_MODE      = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BLOCKS_IN_USE = 4'd1;

   typedef enum logic {
      ACT_LOAD  = 1'b0,
      ACT_ALLOC = 1'b1
   } action_type;

   typedef enum logic [1:0] {
      FIT_FIRST = 2'd0,
      FIT_NEXT  = 2'd1,
      FIT_WORST = 2'd2,
      FIT_BEST  = 2'd3
   } fit_mode_type;

   typedef struct packed {
      action_type          action;
      logic [BLOCK_W-1:0]  block_number;
      logic [AMOUNT_W-1:0] amount;
   } req_type;

   typedef struct packed {
      logic                granted;
      logic [BLOCK_W-1:0]  chosen_block;
      logic [AMOUNT_W-1:0] left_over;
   } rsp_type;

   typedef struct packed {
      logic capture;
      logic issue;
      logic commit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic req_is_load;
      logic cnt_zero;
      logic scan_last;
   } dp_status_type;

endpackage

// ===== hdl/fpba_datapath.sv =====
module fpba_datapath import fpba_pkg::*; #(
   parameter int NBLOCKS   = 16,
   parameter int SIZE_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  req_type                req_data,
   output rsp_type                rsp_data,
   input  logic                   csr_valid,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  ctrl_cmd_type           cmd,
   output dp_status_type          status
);

   localparam int IW    = $clog2(NBLOCKS);
   localparam int CNT_W = $clog2(NBLOCKS + 1);
   localparam int CW    = (SIZE_BITS > AMOUNT_W) ? SIZE_BITS : AMOUNT_W;

   // configuration
   fit_mode_type     mode_ff, mode_in;
   logic [BIU_W-1:0] biu_ff, biu_in;

   // captured request and scan control
   action_type          act_ff, act_in;
   logic [BLOCK_W-1:0]  blk_ff, blk_in;
   logic [AMOUNT_W-1:0] amt_ff, amt_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [IW-1:0]       start_ff, start_in;
   logic [IW-1:0]       addr_ff, addr_in;
   logic [CNT_W-1:0]    issued_ff, issued_in;

   // compare stage
   logic                 cmp_live_ff, cmp_live_in;
   logic [IW-1:0]        cmp_idx_ff;
   logic [SIZE_BITS-1:0] rd_data_ff;
   logic                 rd_valid_ff;
   logic                 found_ff, found_in;
   logic [IW-1:0]        idx_ff, idx_in;
   logic [SIZE_BITS-1:0] hit_val_ff, hit_val_in;

   logic [IW-1:0]      rover_ff, rover_in;
   logic [NBLOCKS-1:0] valid_ff, valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   logic [SIZE_BITS-1:0] size_mem [NBLOCKS];

   logic [CNT_W-1:0]     cnt_req;
   logic [IW-1:0]        start_req;
   logic [SIZE_BITS-1:0] cur_val;
   logic                 fits;
   logic                 take;
   logic [SIZE_BITS-1:0] left;
   logic                 blk_in_range;
   logic                 mem_we;
   logic [IW-1:0]        mem_waddr;
   logic [SIZE_BITS-1:0] mem_wdata;

   // clamp the searched block count to the table depth and pick the scan start block
   always_comb begin
      if (int'(biu_ff) > NBLOCKS) begin
         cnt_req = CNT_W'(NBLOCKS);
      end else begin
         cnt_req = CNT_W'(biu_ff);
      end
      if (mode_ff == FIT_NEXT && CNT_W'(rover_ff) < cnt_req) begin
         start_req = rover_ff;
      end else begin
         start_req = '0;
      end
   end

   assign cur_val      = rd_valid_ff ? rd_data_ff : '0;
   assign fits         = CW'(cur_val) >= CW'(amt_ff);
   assign left         = hit_val_ff - SIZE_BITS'(amt_ff);
   assign blk_in_range = int'(blk_ff) < NBLOCKS;

   always_comb begin
      case (mode_ff)
         FIT_FIRST: take = fits && !found_ff;
         FIT_NEXT:  take = fits && !found_ff;
         FIT_WORST: take = fits && (cur_val > hit_val_ff);
         FIT_BEST:  take = fits && (!found_ff || cur_val < hit_val_ff);
         default:   take = 1'b0;
      endcase
   end

   always_comb begin
      mode_in     = mode_ff;
      biu_in      = biu_ff;
      act_in      = act_ff;
      blk_in      = blk_ff;
      amt_in      = amt_ff;
      cnt_in      = cnt_ff;
      start_in    = start_ff;
      addr_in     = addr_ff;
      issued_in   = issued_ff;
      cmp_live_in = cmd.issue;
      found_in    = found_ff;
      idx_in      = idx_ff;
      hit_val_in  = hit_val_ff;
      rover_in    = rover_ff;
      valid_in    = valid_ff;
      rsp_data_in = rsp_data_ff;
      mem_we      = 1'b0;
      mem_waddr   = '0;
      mem_wdata   = '0;

      if (csr_valid) begin
         case (csr_index)
            CSR_FIT_MODE:      mode_in = fit_mode_type'(csr_wdata[1:0]);
            CSR_BLOCKS_IN_USE: biu_in  = csr_wdata[BIU_W-1:0];
            default:           ;
         endcase
      end

      if (cmd.capture) begin
         act_in     = req_data.action;
         blk_in     = req_data.block_number;
         amt_in     = req_data.amount;
         cnt_in     = cnt_req;
         start_in   = start_req;
         addr_in    = start_req;
         issued_in  = '0;
         found_in   = 1'b0;
         idx_in     = '0;
         hit_val_in = '0;
      end

      // advance the read pointer, wrap at the last searched block
      if (cmd.issue) begin
         issued_in = issued_ff + CNT_W'(1);
         if (CNT_W'(addr_ff) + CNT_W'(1) == cnt_ff) begin
            addr_in = '0;
         end else begin
            addr_in = addr_ff + IW'(1);
         end
      end

      if (cmp_live_ff && take) begin
         found_in   = 1'b1;
         idx_in     = cmp_idx_ff;
         hit_val_in = cur_val;
      end

      if (cmd.commit) begin
         case (act_ff)
            ACT_LOAD: begin
               mem_we                   = blk_in_range;
               mem_waddr                = IW'(blk_ff);
               mem_wdata                = SIZE_BITS'(amt_ff);
               rsp_data_in.granted      = blk_in_range;
               rsp_data_in.chosen_block = blk_in_range ? blk_ff : '0;
               rsp_data_in.left_over    = blk_in_range ?
                                          AMOUNT_W'(SIZE_BITS'(amt_ff)) : '0;
            end
            ACT_ALLOC: begin
               mem_we                   = found_ff;
               mem_waddr                = idx_ff;
               mem_wdata                = left;
               rsp_data_in.granted      = found_ff;
               rsp_data_in.chosen_block = found_ff ? BLOCK_W'(idx_ff) : '0;
               rsp_data_in.left_over    = found_ff ? AMOUNT_W'(left) : '0;
               // a failed next-fit search parks the rover on its start block
               if (mode_ff == FIT_NEXT && cnt_ff != '0) begin
                  rover_in = found_ff ? idx_ff : start_ff;
               end
            end
            default: ;
         endcase
         if (mem_we) begin
            valid_in[mem_waddr] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= FIT_FIRST;
         biu_ff      <= BIU_RESET;
         rover_ff    <= '0;
         valid_ff    <= '0;
         cmp_live_ff <= 1'b0;
      end else begin
         mode_ff     <= mode_in;
         biu_ff      <= biu_in;
         rover_ff    <= rover_in;
         valid_ff    <= valid_in;
         cmp_live_ff <= cmp_live_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff      <= act_in;
      blk_ff      <= blk_in;
      amt_ff      <= amt_in;
      cnt_ff      <= cnt_in;
      start_ff    <= start_in;
      addr_ff     <= addr_in;
      issued_ff   <= issued_in;
      cmp_idx_ff  <= addr_ff;
      found_ff    <= found_in;
      idx_ff      <= idx_in;
      hit_val_ff  <= hit_val_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         size_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff  <= size_mem[addr_ff];
      rd_valid_ff <= valid_ff[addr_ff];
   end

   assign status.req_is_load = (req_data.action == ACT_LOAD);
   assign status.cnt_zero    = (cnt_req == '0);
   assign status.scan_last   = (issued_ff + CNT_W'(1)) == cnt_ff;
   assign rsp_data           = rsp_data_ff;

endmodule

// ===== hdl/fpba_ctrl.sv =====
`include "fit_policy_block_allocator_assert.svh"

module fpba_ctrl import fpba_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SCAN   = 4'b0010,
      ST_DRAIN  = 4'b0100,
      ST_COMMIT = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      req_ready   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               if (status.req_is_load || status.cnt_zero) begin
                  state_in = ST_COMMIT;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            cmd.issue = 1'b1;
            if (status.scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         // last read data is compared here
         ST_DRAIN: begin
            state_in = ST_COMMIT;
         end
         // hold until the output register can take the result
         ST_COMMIT: begin
            if (out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `FPBA_ASSERT_NEXT(ap_accept_leaves_idle, clock, reset, !reset && req_valid && req_ready, state_ff != ST_IDLE, "accepted request did not start work")
   `FPBA_ASSERT_NEXT(ap_commit_waits, clock, reset, !reset && state_ff == ST_COMMIT && !out_free, state_ff == ST_COMMIT && rsp_valid_ff, "commit left while result still pending")
   `FPBA_ASSERT_NEXT(ap_commit_shows_result, clock, reset, !reset && cmd.commit, rsp_valid_ff && state_ff == ST_IDLE, "committed result not presented")
   `FPBA_ASSERT_SAME(ap_result_kept, clock, reset, rsp_valid_ff && !rsp_ready, !cmd.commit, "pending result overwritten")

endmodule

// ===== hdl/fit_policy_block_allocator.sv =====
// Channel   Ports                              Direction  Payload
// req       req_valid req_ready req_data       in         action block_number amount
// rsp       rsp_valid rsp_ready rsp_data       out        granted chosen_block left_over
// csr       csr_valid csr_ready csr_index/wdata in        0 fit_mode, 1 blocks_in_use
//
// A load is accepted, then committed into the result register.
// An allocate is accepted, scans N = min(blocks_in_use, NBLOCKS) blocks at one table
// read a cycle through the single read port of the free-size memory, compares, commits.
// An allocate with no blocks in use skips the scan and goes straight to commit like a load.
// Synchronous reset empties the table, puts the rover on block 0 and resets the CSRs.
// A new request is taken while a result waits; commit stalls until rsp is free.
module fit_policy_block_allocator import fpba_pkg::*; #(
   parameter int NBLOCKS   = 16,
   parameter int SIZE_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_type                rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   assign csr_ready = 1'b1;

   fpba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   fpba_datapath #(
      .NBLOCKS   (NBLOCKS),
      .SIZE_BITS (SIZE_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .status    (status)
   );

endmodule

// ===== tb/fit_policy_block_allocator_test.sv =====
`timescale 1ns / 1ps

module fit_policy_block_allocator_test;
   import fpba_pkg::*;

   localparam int NBLOCKS      = 16;
   localparam int MAX_GAP      = 12;
   localparam int SETTLE       = 40;
   localparam int RANDOM_PHASES = 14;
   localparam int PHASE_ITEMS  = 105;
   localparam longint TIMEOUT_NS = 64'd6_000_000;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   req_type                req_data;
   logic                   rsp_valid;
   logic                   rsp_ready;
   rsp_type                rsp_data;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   // local copy of the allocator state
   logic [AMOUNT_W-1:0] shadow_free [NBLOCKS];
   logic [BLOCK_W-1:0]  shadow_rover;
   fit_mode_type        shadow_mode;
   logic [BIU_W-1:0]    shadow_span;

   rsp_type predicted_grants[$];
   int      mismatches;
   bit      sender_idles;
   bit      receiver_idles;
   int      hold_off_cycles;

   fit_policy_block_allocator #(
      .NBLOCKS   (NBLOCKS),
      .SIZE_BITS (AMOUNT_W)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("[%0t] %s: got %0h, expected %0h", $realtime, what, got, want);
      mismatches++;
   endtask

   // Apply one request to the shadow table and return the response it yields.
   function automatic rsp_type apply_request(input req_type r);
      rsp_type             res;
      int                  span;
      int                  pick;
      int                  start;
      int                  j;
      int                  k;
      logic [AMOUNT_W-1:0] best;
      res = '0;
      if (r.action == ACT_LOAD) begin
         shadow_free[r.block_number] = r.amount;
         res.granted      = 1'b1;
         res.chosen_block = r.block_number;
         res.left_over    = r.amount;
         return res;
      end
      span = (shadow_span > NBLOCKS) ? NBLOCKS : int'(shadow_span);
      pick = -1;
      best = '0;
      if (span > 0) begin
         case (shadow_mode)
            FIT_FIRST: begin
               for (j = 0; j < span; j++)
                  if (pick < 0 && shadow_free[j] >= r.amount) pick = j;
            end
            FIT_NEXT: begin
               start = (shadow_rover < span) ? int'(shadow_rover) : 0;
               j = start;
               for (k = 0; k < span; k++) begin
                  if (pick < 0 && shadow_free[j] >= r.amount) pick = j;
                  j = (j + 1 == span) ? 0 : j + 1;
               end
               // a miss leaves the rover on the block the search began at
               shadow_rover = (pick >= 0) ? BLOCK_W'(pick) : BLOCK_W'(start);
            end
            FIT_WORST: begin
               for (j = 0; j < span; j++)
                  if (shadow_free[j] >= r.amount && shadow_free[j] > best) begin
                     best = shadow_free[j];
                     pick = j;
                  end
            end
            default: begin
               for (j = 0; j < span; j++)
                  if (shadow_free[j] >= r.amount && (pick < 0 || shadow_free[j] < best)) begin
                     best = shadow_free[j];
                     pick = j;
                  end
            end
         endcase
      end
      if (pick >= 0) begin
         shadow_free[pick] = shadow_free[pick] - r.amount;
         res.granted      = 1'b1;
         res.chosen_block = BLOCK_W'(pick);
         res.left_over    = shadow_free[pick];
      end
      return res;
   endfunction

   // Leaves valid high after acceptance; a drain, or the next call when it waits a gap, lowers it.
   task automatic send_request(input req_type r);
      int gap;
      gap = sender_idles ? $urandom_range(0, MAX_GAP) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
      predicted_grants.insert(predicted_grants.size(), apply_request(r));
   endtask

   task automatic issue(input action_type act, input logic [BLOCK_W-1:0] blk,
                        input logic [AMOUNT_W-1:0] amt);
      req_type r;
      r.action       = act;
      r.block_number = blk;
      r.amount       = amt;
      send_request(r);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (predicted_grants.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_FIT_MODE)
         shadow_mode = fit_mode_type'(value[1:0]);
      else if (idx == CSR_BLOCKS_IN_USE)
         shadow_span = value[BIU_W-1:0];
      @(posedge clock);
   endtask

   task automatic configure(input fit_mode_type mode, input logic [BIU_W-1:0] span);
      drain_results();
      write_csr(CSR_FIT_MODE, CSR_DATA_W'(mode));
      write_csr(CSR_BLOCKS_IN_USE, CSR_DATA_W'(span));
   endtask

   function automatic req_type random_request();
      req_type r;
      int      span;
      span = (shadow_span == 0 || shadow_span > NBLOCKS) ? NBLOCKS : int'(shadow_span);
      r.action = ($urandom_range(0, 9) < 4) ? ACT_LOAD : ACT_ALLOC;
      // keep most loads inside the searched range so allocations see them
      if ($urandom_range(0, 3) != 0)
         r.block_number = BLOCK_W'($urandom_range(0, span - 1));
      else
         r.block_number = BLOCK_W'($urandom);
      case ($urandom_range(0, 9))
         0:       r.amount = '0;
         1:       r.amount = '1;
         2, 3, 4: r.amount = AMOUNT_W'($urandom_range(0, 400));
         5, 6:    r.amount = AMOUNT_W'($urandom_range(0, 4000));
         7:       r.amount = AMOUNT_W'($urandom_range(0, 20));
         default: r.amount = AMOUNT_W'($urandom);
      endcase
      return r;
   endfunction

   // Compare every accepted response against the oldest prediction.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (predicted_grants.size() == 0) begin
            report_mismatch("unexpected response", 32'(rsp_data), 32'd0);
         end else begin
            want = predicted_grants.pop_front();
            if (rsp_data.granted !== want.granted)
               report_mismatch("granted", 32'(rsp_data.granted), 32'(want.granted));
            if (rsp_data.chosen_block !== want.chosen_block)
               report_mismatch("chosen_block", 32'(rsp_data.chosen_block),
                               32'(want.chosen_block));
            if (rsp_data.left_over !== want.left_over)
               report_mismatch("left_over", 32'(rsp_data.left_over), 32'(want.left_over));
         end
      end
   end

   initial begin : receiver
      int stall;
      rsp_ready = 1'b0;
      @(posedge clock);
      forever begin
         if (hold_off_cycles > 0) begin
            rsp_ready <= 1'b0;
            repeat (hold_off_cycles) @(posedge clock);
            hold_off_cycles = 0;
         end
         stall = receiver_idles ? $urandom_range(0, MAX_GAP) : 0;
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   task automatic test_reset_state();
      // empty table: a zero request fits block 0, anything larger misses
      issue(ACT_ALLOC, 4'd7, 16'd0);
      issue(ACT_ALLOC, 4'd0, 16'd1);
      issue(ACT_LOAD, 4'd15, 16'hFFFF);
      issue(ACT_LOAD, 4'd0, 16'd100);
      issue(ACT_LOAD, 4'd1, 16'd100);
      issue(ACT_LOAD, 4'd2, 16'd40);
   endtask

   task automatic test_policies();
      configure(FIT_BEST, 5'd16);
      issue(ACT_ALLOC, 4'd0, 16'd30);
      issue(ACT_ALLOC, 4'd0, 16'd100);
      issue(ACT_ALLOC, 4'd0, 16'hFFFF);
      configure(FIT_WORST, 5'd16);
      issue(ACT_ALLOC, 4'd0, 16'd0);
      issue(ACT_ALLOC, 4'd0, 16'd100);
      issue(ACT_ALLOC, 4'd0, 16'd0);
      configure(FIT_NEXT, 5'd2);
      issue(ACT_ALLOC, 4'd0, 16'd50);
      issue(ACT_ALLOC, 4'd0, 16'd60);
      // both misses leave the rover on block 0
      configure(FIT_NEXT, 5'd1);
      issue(ACT_ALLOC, 4'd0, 16'd0);
      issue(ACT_ALLOC, 4'd0, 16'd1);
   endtask

   task automatic test_span_limits();
      configure(FIT_FIRST, 5'd0);
      issue(ACT_ALLOC, 4'd0, 16'd0);
      configure(FIT_FIRST, 5'd31);
      issue(ACT_LOAD, 4'd15, 16'd500);
      issue(ACT_ALLOC, 4'd3, 16'd400);
      configure(FIT_WORST, 5'd4);
      issue(ACT_LOAD, 4'd9, 16'd1000);
      issue(ACT_ALLOC, 4'd9, 16'd900);
      issue(ACT_ALLOC, 4'd0, 16'd0);
   endtask

   task automatic test_random_phases();
      logic [BIU_W-1:0] span;
      int               phase;
      int               n;
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase % 7)
            0:       span = 5'd16;
            1:       span = 5'd1;
            2:       span = 5'd2;
            3:       span = BIU_W'($urandom_range(3, 15));
            4:       span = 5'd16;
            5:       span = BIU_W'($urandom_range(17, 31));
            default: span = BIU_W'($urandom_range(1, 16));
         endcase
         configure(fit_mode_type'(phase % 4), span);
         sender_idles   = (phase % 5) != 3;
         receiver_idles = (phase % 6) != 4;
         for (n = 0; n < PHASE_ITEMS; n++)
            send_request(random_request());
      end
      sender_idles   = 1'b1;
      receiver_idles = 1'b1;
   endtask

   task automatic test_backpressure();
      int n;
      configure(FIT_NEXT, 5'd16);
      sender_idles    = 1'b0;
      hold_off_cycles = 300;
      for (n = 0; n < 30; n++)
         send_request(random_request());
      sender_idles = 1'b1;
   endtask

   task automatic test_sender_pause();
      int n;
      configure(FIT_BEST, 5'd8);
      for (n = 0; n < 20; n++)
         send_request(random_request());
      drain_results();
      for (n = 0; n < 20; n++)
         send_request(random_request());
   endtask

   initial begin
      int i;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      for (i = 0; i < NBLOCKS; i++) shadow_free[i] = '0;
      shadow_rover    = '0;
      shadow_mode     = FIT_FIRST;
      shadow_span     = BIU_RESET;
      mismatches      = 0;
      sender_idles    = 1'b1;
      receiver_idles  = 1'b1;
      hold_off_cycles = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_state();
      test_policies();
      test_span_limits();
      test_random_phases();
      test_backpressure();
      test_sender_pause();

      drain_results();
      repeat (SETTLE) @(posedge clock);
      if (predicted_grants.size() != 0)
         report_mismatch("responses never arrived", 32'(predicted_grants.size()), 32'd0);
      if (mismatches == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/fpba_pkg.sv
hdl/fpba_datapath.sv
hdl/fpba_ctrl.sv
hdl/fit_policy_block_allocator.sv
tb/fit_policy_block_allocator_test.sv
